// ===== design/lfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LED pixel frame encoder.
// No dependencies; imported by every module of the block.
package lfe_pkg;

   localparam int LANES        = 3;
   localparam int LEVEL_W      = 17;
   localparam int DUTY_W       = 8;
   localparam int REG_W        = 11;
   localparam int LANE_STAGES  = 7;
   localparam int SLOT_BYTES   = 4;
   localparam int MAX_BYTES    = SLOT_BYTES + 1;
   localparam int CNT_W        = 3;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 8;
   localparam int CSR_ADDR_W   = 3;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] REG_STRIP_ID       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DISPLAY_LENGTH = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_LENGTH   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DATA_TAG       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RECIPIENT_TAG  = 3'd4;

   localparam logic [5:0]       STRIP_ID_RESET       = 6'd0;
   localparam logic [REG_W-1:0] DISPLAY_LENGTH_RESET = 11'd142;
   localparam logic [REG_W-1:0] TOTAL_LENGTH_RESET   = 11'd160;
   localparam logic [1:0]       DATA_TAG_RESET       = 2'd0;
   localparam logic [1:0]       RECIPIENT_TAG_RESET  = 2'd1;

   // linear segment of the curve: byte = floor(x * 1000 / 2312448), x <= 5242
   localparam logic [LEVEL_W-1:0] LOW_MAX     = 17'd5242;
   localparam logic [LEVEL_W-1:0] LOW_ONE_MIN = 17'd2313;
   localparam logic [LEVEL_W-1:0] LOW_TWO_MIN = 17'd4625;

   // cubic segment: n = 25x + 2^18, byte = floor(n^3 / 2^40 / 24389)
   localparam int N_W    = 21;
   localparam int SQ_W   = 2 * N_W;
   localparam int CUBE_W = 63;
   localparam int T_W    = 23;
   localparam int PROD_W = 41;
   localparam int QE_W   = 9;
   localparam int Q_W    = 10;
   localparam int CHK_W  = 25;
   localparam logic [N_W-1:0]    CUBE_MUL    = 21'd25;
   localparam logic [N_W-1:0]    CUBE_OFFSET = 21'd262144;
   localparam logic [PROD_W-1:0] RECIP       = 41'd176102;   // floor(2^32 / 24389)
   localparam logic [CHK_W-1:0]  DIVISOR     = 25'd24389;
   localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;

   typedef struct packed {
      logic       header;
      logic       color;
      logic       frame_end;
      logic [7:0] header_byte;
      logic [1:0] tag;
   } slot_info_type;

endpackage

// ===== design/led_pixel_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the LED pixel frame encoder: registers, slot counter, lanes, merge.
// Depends on lfe_pkg, lfe_lane and lfe_merge.
//
// Usage:
//   req_* takes one pixel slot per transfer: red, green and blue lightness, 17 bits each,
//   65536 = 1.0. rsp_* returns packet bytes: four per slot, five on slot 0 of a frame
//   (header byte first). rsp_tlast marks the last byte of a slot, rsp_tuser the last
//   byte of a frame. csr_* writes the five registers; write only while idle.
//   Three lanes (red, green, blue) each run a seven-stage curve pipeline; the merge
//   stage packs their bytes and shifts them out one per cycle while rsp_tready is high.
//   The first byte of a slot is valid once the slot has passed the input registers, the
//   seven lane stages, the lane done flag and the merge buffer. A new slot is accepted
//   only after the previous one has left the lanes for the merge stage; the next slot
//   is computed while the previous slot's bytes drain.
//   When the receiver stalls, the byte on rsp_* holds; once the next slot is
//   computed it waits in the lanes and req_tready stays low until it can be loaded.
//   Reset (synchronous) restores register defaults, empties the pipeline and
//   returns the slot counter to the start of a frame.
module led_pixel_frame_encoder_core
   import lfe_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // red_level, green_level, blue_level, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // frame_last
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMP_W  = (SLOT_W + 1 > REG_W) ? SLOT_W + 1 : REG_W;
   localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SLOTS);

   logic [5:0]        strip_id_ff;
   logic [REG_W-1:0]  display_length_ff;
   logic [REG_W-1:0]  total_length_ff;
   logic [1:0]        data_tag_ff;
   logic [1:0]        recipient_tag_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              busy_ff, start_ff;
   slot_info_type     info_ff, info_in;
   logic [LEVEL_W-1:0] level_ff [LANES];

   logic [CMP_W-1:0]  total_eff, slot_next;
   logic              accept, take, load_ready, all_done;
   logic [DUTY_W-1:0] duty [LANES];
   logic [LANES-1:0]  done;

   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & ~busy_ff;
   assign all_done   = &done;
   assign take       = all_done & load_ready;

   always_comb begin
      if (total_length_ff == '0) begin
         total_eff = CMP_W'(1);
      end else if (CMP_W'(total_length_ff) > MAX_C) begin
         total_eff = MAX_C;
      end else begin
         total_eff = CMP_W'(total_length_ff);
      end
      slot_next             = CMP_W'(slot_ff) + CMP_W'(1);
      info_in.header        = (slot_ff == '0);
      info_in.color         = CMP_W'(slot_ff) < CMP_W'(display_length_ff);
      info_in.frame_end     = (slot_next >= total_eff);
      info_in.header_byte   = {recipient_tag_ff, strip_id_ff};
      info_in.tag           = data_tag_ff;
      slot_in = info_in.frame_end ? '0 : slot_next[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff     <= info_in;
         level_ff[0] <= req_tdata[LEVEL_W-1:0];
         level_ff[1] <= req_tdata[2*LEVEL_W-1:LEVEL_W];
         level_ff[2] <= req_tdata[3*LEVEL_W-1:2*LEVEL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_id_ff       <= STRIP_ID_RESET;
         display_length_ff <= DISPLAY_LENGTH_RESET;
         total_length_ff   <= TOTAL_LENGTH_RESET;
         data_tag_ff       <= DATA_TAG_RESET;
         recipient_tag_ff  <= RECIPIENT_TAG_RESET;
         slot_ff           <= '0;
         busy_ff           <= 1'b0;
         start_ff          <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               REG_STRIP_ID:       strip_id_ff       <= csr_wdata[5:0];
               REG_DISPLAY_LENGTH: display_length_ff <= csr_wdata;
               REG_TOTAL_LENGTH:   total_length_ff   <= csr_wdata;
               REG_DATA_TAG:       data_tag_ff       <= csr_wdata[1:0];
               REG_RECIPIENT_TAG:  recipient_tag_ff  <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (accept) begin
            slot_ff <= slot_in;
         end
         start_ff <= accept;
         busy_ff  <= accept | (busy_ff & ~take);
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      lfe_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (start_ff),
         .take  (take),
         .level (level_ff[g]),
         .duty  (duty[g]),
         .done  (done[g])
      );
   end

   lfe_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (all_done),
      .load_ready (load_ready),
      .info       (info_ff),
      .red_duty   (duty[0]),
      .green_duty (duty[1]),
      .blue_duty  (duty[2]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== design/lfe_lane.sv =====
`timescale 1ns / 1ps
// One color lane: inverse CIE lightness curve to a duty byte, seven register stages.
// Depends on lfe_pkg.
module lfe_lane
   import lfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               take,
   input  logic [LEVEL_W-1:0] level,
   output logic [DUTY_W-1:0]  duty,
   output logic               done
);

   logic [LANE_STAGES-1:0] valid_ff;
   logic                   done_ff;

   logic              sat_ff, low_ff;
   logic [1:0]        lowq_ff;
   logic [N_W-1:0]    n1_ff, n2_ff;
   logic [SQ_W-1:0]   sq2_ff, ph3_ff, pl3_ff;
   logic [T_W-1:0]    t4_ff, t5_ff;
   logic [QE_W-1:0]   qe5_ff;
   logic [Q_W-1:0]    q6_ff;
   logic [DUTY_W-1:0] duty_ff;

   logic [N_W-1:0]    n1_in;
   logic [1:0]        lowq_in;
   logic [CUBE_W-1:0] cube;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    qp;
   logic [CHK_W-1:0]  chk;
   logic [Q_W-1:0]    q6_in;
   logic [DUTY_W-1:0] duty_in;

   always_comb begin
      n1_in = N_W'(level[15:0]) * CUBE_MUL + CUBE_OFFSET;
      if (level >= LOW_TWO_MIN) begin
         lowq_in = 2'd2;
      end else if (level >= LOW_ONE_MIN) begin
         lowq_in = 2'd1;
      end else begin
         lowq_in = 2'd0;
      end
      cube  = (CUBE_W'(ph3_ff) << N_W) + CUBE_W'(pl3_ff);
      prod  = PROD_W'(t4_ff) * RECIP;
      qp    = Q_W'(qe5_ff) + Q_W'(1);
      chk   = CHK_W'(qp) * DIVISOR;
      q6_in = (CHK_W'(t5_ff) >= chk) ? qp : Q_W'(qe5_ff);
      if (sat_ff) begin
         duty_in = DUTY_MAX;
      end else if (low_ff) begin
         duty_in = DUTY_W'(lowq_ff);
      end else if (q6_ff > Q_W'(DUTY_MAX)) begin
         duty_in = DUTY_MAX;
      end else begin
         duty_in = q6_ff[DUTY_W-1:0];
      end
   end

   // payload stages; one slot in flight, so they simply settle
   always_ff @(posedge clock) begin
      sat_ff  <= level[LEVEL_W-1];
      low_ff  <= (level <= LOW_MAX);
      lowq_ff <= lowq_in;
      n1_ff   <= n1_in;
      sq2_ff  <= SQ_W'(n1_ff) * SQ_W'(n1_ff);
      n2_ff   <= n1_ff;
      ph3_ff  <= SQ_W'(sq2_ff[SQ_W-1:N_W]) * SQ_W'(n2_ff);
      pl3_ff  <= SQ_W'(sq2_ff[N_W-1:0]) * SQ_W'(n2_ff);
      t4_ff   <= cube[CUBE_W-1:CUBE_W-T_W];
      qe5_ff  <= prod[PROD_W-1:32];
      t5_ff   <= t4_ff;
      q6_ff   <= q6_in;
      duty_ff <= duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[LANE_STAGES-2:0], start};
         done_ff  <= valid_ff[LANE_STAGES-1] | (done_ff & ~take);
      end
   end

   assign duty = duty_ff;
   assign done = done_ff;

endmodule

// ===== design/lfe_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: packs the three lane bytes into tagged bytes, 6 data bits each, and sends them.
// Depends on lfe_pkg.
module lfe_merge
   import lfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  slot_info_type         info,
   input  logic [DUTY_W-1:0]     red_duty,
   input  logic [DUTY_W-1:0]     green_duty,
   input  logic [DUTY_W-1:0]     blue_duty,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [7:0]       buf_ff [MAX_BYTES];
   logic [7:0]       buf_in [MAX_BYTES];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fend_ff;
   logic             xfer, load;
   logic [7:0]       pkt [SLOT_BYTES];

   assign xfer       = (cnt_ff != '0) & rsp_tready;
   assign load_ready = (cnt_ff == '0) | ((cnt_ff == CNT_W'(1)) & xfer);
   assign load       = load_valid & load_ready;

   always_comb begin
      if (info.color) begin
         pkt[0] = {info.tag, blue_duty[7:2]};
         pkt[1] = {info.tag, blue_duty[1:0], green_duty[7:4]};
         pkt[2] = {info.tag, green_duty[3:0], red_duty[7:6]};
         pkt[3] = {info.tag, red_duty[5:0]};
      end else begin
         for (int i = 0; i < SLOT_BYTES; i++) begin
            pkt[i] = {info.tag, 6'd0};
         end
      end

      for (int i = 0; i < MAX_BYTES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (xfer) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
      end
      cnt_in = cnt_ff - CNT_W'(xfer);

      if (load) begin
         if (info.header) begin
            buf_in[0] = info.header_byte;
            for (int i = 0; i < SLOT_BYTES; i++) begin
               buf_in[i + 1] = pkt[i];
            end
            cnt_in = CNT_W'(MAX_BYTES);
         end else begin
            for (int i = 0; i < SLOT_BYTES; i++) begin
               buf_in[i] = pkt[i];
            end
            cnt_in = CNT_W'(SLOT_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (load) begin
         fend_ff <= info.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = buf_ff[0];
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));
   assign rsp_tuser  = (cnt_ff == CNT_W'(1)) & fend_ff;

endmodule

// ===== bench/lfe_frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for led_pixel_frame_encoder_core: follows register writes, predicts the packet
// bytes of each accepted pixel slot and compares them with the rsp_* transfers.
// Depends on lfe_pkg.
module lfe_frame_checker
   import lfe_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int MAX_REPORTS = 200;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       slot_end;
      logic       frame_end;
   } packet_byte_type;

   packet_byte_type pending_bytes[$];
   packet_byte_type seen;
   packet_byte_type want;

   logic [5:0]       strip_id;
   logic [REG_W-1:0] display_length;
   logic [REG_W-1:0] total_length;
   logic [1:0]       data_tag;
   logic [1:0]       recipient_tag;
   int               slot_index;
   int               errors = 0;

   function automatic logic [7:0] lightness_to_duty(input logic [LEVEL_W-1:0] level);
      logic [63:0] x;
      logic [63:0] n;
      logic [63:0] q;
      x = 64'(level);
      if (x <= 64'd5242) return 8'((x * 64'd1000) / 64'd2312448);
      if (x >= 64'd65536) return 8'd255;
      n = 64'd25 * x + 64'd262144;
      q = (n * n * n) / (64'd24389 << 40);
      return (q >= 64'd255) ? 8'd255 : q[7:0];
   endfunction

   task automatic encode_slot(input logic [REQ_DATA_W-1:0] data);
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic [7:0]      pkt [4];
      packet_byte_type entry;
      int              frame_slots;
      bit              wraps;
      frame_slots = (total_length == 0) ? 1 :
                    (int'(total_length) > MAX_SLOTS) ? MAX_SLOTS : int'(total_length);
      wraps = (slot_index + 1 >= frame_slots);
      if (slot_index == 0) begin
         entry.pkt_byte = {recipient_tag, strip_id};
         entry.slot_end = 1'b0;
         entry.frame_end = 1'b0;
         pending_bytes = {pending_bytes, entry};
      end
      if (slot_index < int'(display_length)) begin
         red   = lightness_to_duty(data[LEVEL_W-1:0]);
         green = lightness_to_duty(data[2*LEVEL_W-1:LEVEL_W]);
         blue  = lightness_to_duty(data[3*LEVEL_W-1:2*LEVEL_W]);
         pkt[0] = {data_tag, blue[7:2]};
         pkt[1] = {data_tag, blue[1:0], green[7:4]};
         pkt[2] = {data_tag, green[3:0], red[7:6]};
         pkt[3] = {data_tag, red[5:0]};
      end else begin
         foreach (pkt[i]) pkt[i] = {data_tag, 6'd0};
      end
      foreach (pkt[i]) begin
         entry.pkt_byte = pkt[i];
         entry.slot_end = (i == 3);
         entry.frame_end = (i == 3) && wraps;
         pending_bytes = {pending_bytes, entry};
      end
      slot_index = wraps ? 0 : slot_index + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         strip_id = STRIP_ID_RESET;
         display_length = DISPLAY_LENGTH_RESET;
         total_length = TOTAL_LENGTH_RESET;
         data_tag = DATA_TAG_RESET;
         recipient_tag = RECIPIENT_TAG_RESET;
         slot_index = 0;
         pending_bytes.delete();
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               REG_STRIP_ID:       strip_id = csr_wdata[5:0];
               REG_DISPLAY_LENGTH: display_length = csr_wdata;
               REG_TOTAL_LENGTH:   total_length = csr_wdata;
               REG_DATA_TAG:       data_tag = csr_wdata[1:0];
               REG_RECIPIENT_TAG:  recipient_tag = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.pkt_byte = rsp_tdata;
            seen.slot_end = rsp_tlast;
            seen.frame_end = rsp_tuser;
            if (pending_bytes.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected transfer, got byte %h last %b frame %b",
                           $time, seen.pkt_byte, seen.slot_end, seen.frame_end);
            end else begin
               want = pending_bytes.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: expected byte %h last %b frame %b, got byte %h last %b frame %b",
                              $time, want.pkt_byte, want.slot_end, want.frame_end,
                              seen.pkt_byte, seen.slot_end, seen.frame_end);
               end
            end
         end
         if (req_tvalid && req_tready) encode_slot(req_tdata);
      end
      fail_count <= errors;
      outstanding <= pending_bytes.size();
   end

endmodule

// ===== bench/led_pixel_frame_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for led_pixel_frame_encoder_core: clock, reset, pixel and register stimulus,
// random receiver stalls, watchdog and verdict. Depends on lfe_pkg, the core and lfe_frame_checker.
module led_pixel_frame_encoder_core_tb;
   import lfe_pkg::*;

   localparam int MAX_SLOTS   = 1024;
   localparam int QUIET_LIMIT = 2000;
   localparam int SLOT_TARGET = 370;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // red_level, green_level, blue_level, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_byte
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [REG_W-1:0]      csr_wdata = '0;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;
   int rsp_hold = 0;
   bit rsp_steady = 1'b0;
   bit req_steady = 1'b0;
   int slots_sent = 0;

   logic [LEVEL_W-1:0] corner_levels [10][3] = '{
      '{17'd0,      17'd0,      17'd0},
      '{17'd65536,  17'd65536,  17'd65536},
      '{17'd131071, 17'd131071, 17'd131071},
      '{17'd5242,   17'd5243,   17'd65535},
      '{17'd2312,   17'd2313,   17'd4624},
      '{17'd4625,   17'd1,      17'd65537},
      '{17'd65536,  17'd0,      17'd0},
      '{17'd0,      17'd65536,  17'd0},
      '{17'd0,      17'd0,      17'd65536},
      '{17'd98304,  17'd43690,  17'd21845}
   };

   led_pixel_frame_encoder_core #(.MAX_SLOTS(MAX_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   lfe_frame_checker #(.MAX_SLOTS(MAX_SLOTS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // receiver: random hold-off after each transfer, with occasional stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         rsp_hold = rsp_steady ? 0 : $urandom_range(0, 4);
         rsp_tready <= (rsp_hold == 0);
      end else if (!rsp_tready) begin
         if (rsp_hold != 0) rsp_hold = rsp_hold - 1;
         rsp_tready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [LEVEL_W-1:0] draw_level();
      case ($urandom_range(0, 9))
         0: return LEVEL_W'($urandom_range(0, 5242));
         1: return LEVEL_W'($urandom_range(5238, 5248));
         2: return LEVEL_W'($urandom_range(65530, 65536));
         3: return LEVEL_W'($urandom_range(65537, 131071));
         default: return LEVEL_W'($urandom_range(5243, 65535));
      endcase
   endfunction

   task automatic send_slot(input logic [LEVEL_W-1:0] red, green, blue);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({blue, green, red});
      do @(posedge clock); while (!req_tready);
      slots_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index, input int value);
      csr_wen <= 1'b1;
      csr_addr <= index;
      csr_wdata <= REG_W'(value);
      @(posedge clock);
   endtask

   task automatic run_phase(input int strip, disp, total, dtag, rtag, count);
      wait_idle();
      write_reg(REG_STRIP_ID, strip);
      write_reg(REG_DISPLAY_LENGTH, disp);
      write_reg(REG_TOTAL_LENGTH, total);
      write_reg(REG_DATA_TAG, dtag);
      write_reg(REG_RECIPIENT_TAG, rtag);
      csr_wen <= 1'b0;
      req_steady = ($urandom_range(0, 3) == 0);
      repeat (count) send_slot(draw_level(), draw_level(), draw_level());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_levels[i])
         send_slot(corner_levels[i][0], corner_levels[i][1], corner_levels[i][2]);
      run_phase(63, 3, 5, 3, 0, 20);
      run_phase(0, 0, 1, 1, 3, 8);
      run_phase(42, 2047, 0, 2, 1, 8);
      run_phase(21, 1024, 2047, 2, 2, 12);
      // slot counter already past the shortened frame
      run_phase(21, 1024, 4, 2, 2, 6);
      run_phase(5, 8, 3, 1, 0, 12);
      while (slots_sent < SLOT_TARGET)
         run_phase($urandom_range(0, 63),
                   ($urandom_range(0, 7) == 0) ? 2047 : $urandom_range(0, 14),
                   ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12),
                   $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(15, 35));
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/lfe_pkg.sv
design/lfe_lane.sv
design/lfe_merge.sv
design/led_pixel_frame_encoder_core.sv
bench/lfe_frame_checker.sv
bench/led_pixel_frame_encoder_core_tb.sv
